// ===== src/mbtb_pkg.sv =====
`timescale 1ns / 1ps
package mbtb_pkg;

  typedef enum logic [2:0] {
    KIND_TICK   = 3'd0,
    KIND_ALLOC  = 3'd1,
    KIND_CONFIG = 3'd2,
    KIND_SET    = 3'd3,
    KIND_START  = 3'd4,
    KIND_STOP   = 3'd5,
    KIND_READ   = 3'd6,
    KIND_NOP    = 3'd7
  } kind_e;

  localparam logic [1:0] RS_IDLE = 2'd0;
  localparam logic [1:0] RS_STOP = 2'd1;
  localparam logic [1:0] RS_RUN  = 2'd2;

  localparam logic [0:0] CFG_SHORT_MODE = 1'b0;
  localparam logic [0:0] CFG_SHORT_RATE = 1'b1;

  localparam logic [15:0] SAT_MAX = 16'hFFFF;
  localparam int unsigned ADDR_LIMIT = 64;

  typedef struct packed {
    logic [2:0]  kind;
    logic [5:0]  channel;
    logic [2:0]  base_select;
    logic        count_up;
    logic        short_allowed;
    logic [1:0]  run_state;
    logic [15:0] count_value;
  } req_t;

  typedef struct packed {
    logic        granted;
    logic [5:0]  channel_out;
    logic [15:0] read_value;
  } rsp_t;

  // Divisors of the timebases; zero marks a timebase that does not exist.
  function automatic logic [14:0] base_div(input logic [3:0] b);
    logic [14:0] d;
    case (b)
      4'd0: d = 15'd1;
      4'd1: d = 15'd4;
      4'd2: d = 15'd40;
      4'd3: d = 15'd200;
      4'd4: d = 15'd400;
      4'd5: d = 15'd2400;
      4'd6: d = 15'd12000;
      4'd7: d = 15'd24000;
      default: d = 15'd0;
    endcase
    return d;
  endfunction

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_BASE,
    ST_DIV,
    ST_SCAN,
    ST_RD,
    ST_WB,
    ST_DONE,
    ST_CLR
  } exec_state_e;

endpackage

// ===== src/mbtb_ram.sv =====
`timescale 1ns / 1ps
module mbtb_ram #(
  parameter int Width = 16,
  parameter int Depth = 64
) (
  input  logic                                        clk_i,
  input  logic                                        we_i,
  input  logic [((Depth > 1) ? $clog2(Depth) : 1)-1:0] waddr_i,
  input  logic [Width-1:0]                            wdata_i,
  input  logic [((Depth > 1) ? $clog2(Depth) : 1)-1:0] raddr_i,
  output logic [Width-1:0]                            rdata_o
);
  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) mem_q[waddr_i] <= wdata_i;
    rdata_o <= mem_q[raddr_i];
  end
endmodule

// ===== src/mbtb_front.sv =====
`timescale 1ns / 1ps
// Two-entry request queue between the input port and the execution unit.
module mbtb_front (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_i,
  output logic           full_o,
  input  mbtb_pkg::req_t req_i,
  output logic           req_valid_o,
  input  logic           req_take_i,
  output mbtb_pkg::req_t req_o
);
  import mbtb_pkg::*;

  req_t       buf_q [2];
  logic       rd_q, rd_d, wr_q, wr_d;
  logic [1:0] cnt_q, cnt_d;
  logic       do_push, do_pop;

  assign full_o      = (cnt_q == 2'd2);
  assign req_valid_o = (cnt_q != 2'd0);
  assign req_o       = buf_q[rd_q];
  assign do_push     = push_i && !full_o;
  assign do_pop      = req_take_i && req_valid_o;

  always_comb begin
    rd_d  = rd_q ^ do_pop;
    wr_d  = wr_q ^ do_push;
    cnt_d = cnt_q + {1'b0, do_push} - {1'b0, do_pop};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rd_q  <= 1'b0;
      wr_q  <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      rd_q  <= rd_d;
      wr_q  <= wr_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) buf_q[wr_q] <= req_i;
  end
endmodule

// ===== src/mbtb_exec.sv =====
`timescale 1ns / 1ps
// Execution unit: for a tick, a timebase walk and then a scan that reads and writes back each timer entry in turn.
module mbtb_exec #(
  parameter int CHANNELS  = 64,
  parameter int TIMEBASES = 8
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           req_valid_i,
  output logic           req_take_o,
  input  mbtb_pkg::req_t req_i,
  input  logic           short_mode_i,
  input  logic [7:0]     short_rate_i,
  output logic           rsp_valid_o,
  input  logic           rsp_ready_i,
  output mbtb_pkg::rsp_t rsp_o
);
  import mbtb_pkg::*;

  localparam int CW = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam int TW = $clog2(TIMEBASES + 1);
  localparam int LIM = (CHANNELS < ADDR_LIMIT) ? CHANNELS : ADDR_LIMIT;

  exec_state_e st_q, st_d;
  req_t        req_q;
  logic [CW:0] idx_q, idx_d;
  logic [TW-1:0] tb_q, tb_d;
  logic [15:0] bph_q [TIMEBASES];
  logic [15:0] sph_q [TIMEBASES];
  logic        nstep_q [TIMEBASES];
  logic [15:0] sstep_q [TIMEBASES];
  logic [CHANNELS-1:0] used_q;
  rsp_t        rsp_q, rsp_d;
  logic        rsp_valid_q;

  // Per-entry RAM: {mode[6:0], count[15:0]}.
  logic          we;
  logic [CW-1:0] waddr, raddr;
  logic [22:0]   wdata, rdata;

  mbtb_ram #(.Width(23), .Depth(CHANNELS)) u_ram (
    .clk_i, .we_i(we), .waddr_i(waddr), .wdata_i(wdata),
    .raddr_i(raddr), .rdata_o(rdata)
  );

  // Division of the accelerated phase. Divisors of one and four take a shift;
  // the larger ones are subtracted once per cycle, as the quotient stays small.
  logic [16:0] rem_q, rem_d;
  logic [15:0] quo_q, quo_d;
  logic [14:0] cur_div;
  logic [16:0] sum_p;
  logic [15:0] bph_n;

  logic [TW-1:0] tb_idx;
  assign tb_idx  = tb_q;
  assign cur_div = base_div(4'(tb_idx));
  assign sum_p   = {1'b0, sph_q[tb_idx[$clog2(TIMEBASES > 1 ? TIMEBASES : 2)-1:0]]}
                   + {9'd0, short_rate_i};
  assign bph_n   = bph_q[tb_idx[$clog2(TIMEBASES > 1 ? TIMEBASES : 2)-1:0]] + 16'd1;

  // Timer update arithmetic for the entry just read.
  logic [1:0]  m_rs;
  logic [2:0]  m_base;
  logic        m_up, m_sh;
  logic [15:0] m_cnt, step, new_cnt;
  logic        m_ok;
  assign m_rs   = rdata[17:16];
  assign m_base = rdata[20:18];
  assign m_up   = rdata[21];
  assign m_sh   = rdata[22];
  assign m_cnt  = rdata[15:0];
  assign m_ok   = ({1'b0, m_base} < 4'(TIMEBASES)) && (base_div({1'b0, m_base}) != 15'd0);

  always_comb begin
    step = 16'd0;
    for (int b = 0; b < TIMEBASES; b++) begin
      if (b == int'(m_base)) step = (short_mode_i && m_sh) ? sstep_q[b] : {15'd0, nstep_q[b]};
    end
    if (!m_up) new_cnt = (m_cnt > step) ? m_cnt - step : 16'd0;
    else new_cnt = (step < SAT_MAX && m_cnt < SAT_MAX - step) ? m_cnt + step : SAT_MAX;
  end

  logic [1:0] wr_rs;
  assign wr_rs = (req_q.run_state == RS_RUN) ? RS_RUN : RS_STOP;

  logic            alloc_hit;
  logic [CW-1:0]   alloc_idx;
  always_comb begin
    alloc_hit = 1'b0;
    alloc_idx = '0;
    for (int i = LIM - 1; i >= 0; i--) begin
      if (!used_q[i]) begin
        alloc_hit = 1'b1;
        alloc_idx = CW'(i);
      end
    end
  end

  logic ch_ok;
  assign ch_ok = (int'(req_q.channel) < CHANNELS);

  always_comb begin
    st_d = st_q; idx_d = idx_q; tb_d = tb_q;
    rem_d = rem_q; quo_d = quo_q;
    rsp_d = rsp_q;
    req_take_o = 1'b0;
    we = 1'b0; waddr = idx_q[CW-1:0]; wdata = '0;
    raddr = idx_q[CW-1:0];
    case (st_q)
      ST_CLR: begin
        // Zero every timer entry once after reset.
        we = 1'b1;
        if (idx_q == (CW+1)'(CHANNELS - 1)) begin
          idx_d = '0;
          st_d  = ST_IDLE;
        end else idx_d = idx_q + 1'b1;
      end
      ST_IDLE: begin
        if (req_valid_i && !rsp_valid_q) begin
          req_take_o = 1'b1;
          rsp_d = '0;
          idx_d = '0;
          tb_d  = '0;
          st_d  = (kind_e'(req_i.kind) == KIND_TICK) ? ST_BASE : ST_RD;
        end
      end
      ST_BASE: begin
        if (tb_q >= TW'(TIMEBASES) || cur_div == 15'd0) begin
          st_d = ST_SCAN;
        end else if (short_mode_i && sum_p >= {2'd0, cur_div} && cur_div > 15'd4) begin
          rem_d = sum_p; quo_d = '0; st_d = ST_DIV;
        end else begin
          tb_d = tb_q + 1'b1;
        end
      end
      ST_DIV: begin
        if (rem_q >= {2'd0, cur_div}) begin
          rem_d = rem_q - {2'd0, cur_div};
          quo_d = quo_q + 16'd1;
        end else begin
          st_d = ST_BASE; tb_d = tb_q + 1'b1;
        end
      end
      ST_SCAN: begin
        // Read issued for idx; data in ST_WB.
        if (idx_q == (CW+1)'(CHANNELS)) st_d = ST_DONE;
        else st_d = ST_WB;
      end
      ST_WB: begin
        if (m_rs == RS_RUN && m_ok && step != 16'd0) begin
          we = 1'b1; wdata = {rdata[22:16], new_cnt};
        end
        idx_d = idx_q + 1'b1;
        raddr = idx_d[CW-1:0];
        st_d  = ST_SCAN;
      end
      ST_RD: begin
        raddr = CW'(req_q.channel);
        st_d  = ST_DONE;
        case (kind_e'(req_q.kind))
          KIND_ALLOC: begin
            if (req_q.run_state != RS_IDLE && alloc_hit) begin
              we = 1'b1; waddr = alloc_idx;
              wdata = {req_q.short_allowed, req_q.count_up, req_q.base_select, wr_rs,
                       req_q.count_value};
              rsp_d.granted = 1'b1;
              rsp_d.channel_out = 6'(alloc_idx);
            end
          end
          KIND_CONFIG: begin
            if (ch_ok) begin
              we = 1'b1; waddr = CW'(req_q.channel);
              wdata = (req_q.run_state == RS_IDLE) ? '0 :
                {req_q.short_allowed, req_q.count_up, req_q.base_select, wr_rs,
                 req_q.count_value};
            end
          end
          KIND_SET, KIND_START, KIND_STOP, KIND_READ: st_d = ST_WB;
          default: ;
        endcase
      end
      ST_DONE: st_d = ST_IDLE;
      default: st_d = ST_IDLE;
    endcase
    // Read-modify-write ops reuse ST_WB with the request's channel.
    if (st_q == ST_WB && kind_e'(req_q.kind) != KIND_TICK) begin
      we = 1'b0; waddr = CW'(req_q.channel); idx_d = idx_q;
      st_d = ST_DONE;
      if (ch_ok) begin
        case (kind_e'(req_q.kind))
          KIND_SET: begin we = 1'b1; wdata = {rdata[22:16], req_q.count_value}; end
          KIND_START: if (m_rs != RS_IDLE) begin
            we = 1'b1; wdata = {rdata[22:18], RS_RUN, m_cnt};
          end
          KIND_STOP: if (m_rs != RS_IDLE) begin
            we = 1'b1; wdata = {rdata[22:18], RS_STOP, m_cnt};
          end
          KIND_READ: rsp_d.read_value = m_cnt;
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= ST_CLR;
      idx_q <= '0;
      tb_q <= '0;
      rsp_valid_q <= 1'b0;
      used_q <= '0;
      for (int b = 0; b < TIMEBASES; b++) begin
        bph_q[b] <= '0; sph_q[b] <= '0; nstep_q[b] <= 1'b0; sstep_q[b] <= '0;
      end
    end else begin
      st_q <= st_d;
      idx_q <= idx_d;
      tb_q <= tb_d;
      if (st_q == ST_DONE) rsp_valid_q <= 1'b1;
      else if (rsp_ready_i) rsp_valid_q <= 1'b0;
      if (we) used_q[waddr] <= (wdata[17:16] != RS_IDLE);
      if (st_q == ST_BASE && (st_d == ST_BASE || st_d == ST_DIV)) begin
        for (int b = 0; b < TIMEBASES; b++) begin
          if (TW'(b) == tb_q) begin
            bph_q[b]   <= ({1'b0, bph_n} >= {2'd0, cur_div}) ? 16'd0 : bph_n;
            nstep_q[b] <= ({1'b0, bph_n} >= {2'd0, cur_div});
            if (!short_mode_i) begin
              sph_q[b] <= '0; sstep_q[b] <= '0;
            end else if (cur_div == 15'd1) begin
              sph_q[b] <= '0; sstep_q[b] <= sum_p[15:0];
            end else if (cur_div == 15'd4) begin
              sph_q[b] <= {14'd0, sum_p[1:0]}; sstep_q[b] <= {1'b0, sum_p[16:2]};
            end else if (st_d == ST_BASE) begin
              sph_q[b] <= sum_p[15:0]; sstep_q[b] <= '0;
            end
          end
        end
      end
      if (st_q == ST_DIV && st_d == ST_BASE) begin
        for (int b = 0; b < TIMEBASES; b++) begin
          if (TW'(b) == tb_q) begin
            sph_q[b]   <= rem_q[15:0];
            sstep_q[b] <= quo_q;
          end
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_take_o) req_q <= req_i;
    rsp_q <= rsp_d;
    rem_q <= rem_d; quo_q <= quo_d;
  end

  assign rsp_valid_o = rsp_valid_q;
  assign rsp_o       = rsp_q;
endmodule

// ===== src/multi_base_timer_bank_unit.sv =====
`timescale 1ns / 1ps
// Channel  | Direction | Handshake          | Payload
// request  | in        | push_i / full_o    | req_i (mbtb_pkg::req_t)
// result   | out       | empty_o / pop_i    | rsp_o (mbtb_pkg::rsp_t)
// config   | in        | cfg_valid_i/ready_o| cfg_index_i, cfg_data_i
// A tick walks the timebases, with a division for each accelerated timebase with a
// divisor above four that divides, then reads and writes back every timer in turn.
// Allocate and configure write in ST_RD; set, start, stop and read read the timer
// and finish in ST_WB. One request executes at a time; two more queue.
// Reset clears phases and registers at once (short_rate to 60); the timers are then
// zeroed by a pass over all CHANNELS entries before the first request executes.
// A result waits in its register until popped and stalls the next request only.
module multi_base_timer_bank_unit #(
  parameter int CHANNELS  = 64,
  parameter int TIMEBASES = 8
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_i,
  output logic           full_o,
  input  mbtb_pkg::req_t req_i,
  output logic           empty_o,
  input  logic           pop_i,
  output mbtb_pkg::rsp_t rsp_o,
  input  logic           cfg_valid_i,
  output logic           cfg_ready_o,
  input  logic           cfg_index_i,
  input  logic [7:0]     cfg_data_i
);
  import mbtb_pkg::*;

  logic       short_mode_q;
  logic [7:0] short_rate_q;
  logic       q_valid, q_take, rsp_valid;
  req_t       q_req;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      short_mode_q <= 1'b0;
      short_rate_q <= 8'd60;
    end else if (cfg_valid_i) begin
      if (cfg_index_i == CFG_SHORT_MODE) short_mode_q <= cfg_data_i[0];
      else short_rate_q <= cfg_data_i;
    end
  end

  mbtb_front u_front (
    .clk_i, .rst_ni, .push_i, .full_o, .req_i,
    .req_valid_o(q_valid), .req_take_i(q_take), .req_o(q_req)
  );

  mbtb_exec #(.CHANNELS(CHANNELS), .TIMEBASES(TIMEBASES)) u_exec (
    .clk_i, .rst_ni, .req_valid_i(q_valid), .req_take_o(q_take), .req_i(q_req),
    .short_mode_i(short_mode_q), .short_rate_i(short_rate_q),
    .rsp_valid_o(rsp_valid), .rsp_ready_i(pop_i), .rsp_o
  );

  assign empty_o = !rsp_valid;
endmodule

// ===== src/mbtb_checker.sv =====
`timescale 1ns / 1ps
module mbtb_checker (
  input logic           clk_i,
  input logic           rst_ni,
  input logic           full_o,
  input logic           empty_o,
  input logic           pop_i,
  input mbtb_pkg::rsp_t rsp_o
);
  a_rsp_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !empty_o && !pop_i |=> !empty_o && $stable(rsp_o)) else $error("result changed");
  a_grant_ch: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !empty_o && !rsp_o.granted |-> rsp_o.channel_out == 6'd0) else $error("stray channel");
  a_excl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !empty_o && rsp_o.granted |-> rsp_o.read_value == 16'd0) else $error("mixed result");
  a_reset: assert property (@(posedge clk_i) $rose(rst_ni) |-> empty_o && !full_o)
    else $error("result after reset");
endmodule

bind multi_base_timer_bank_unit mbtb_checker u_chk (.*);
